>>> hdl/sha256_stream_hash_core_assert.svh
// assertion macros for the sha256 stream hash core
`ifndef SHA256_STREAM_HASH_CORE_ASSERT_SVH
`define SHA256_STREAM_HASH_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/sha256_pkg.sv
`timescale 1ns / 1ps
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t IV0 = 32'h6a09e667;
  localparam word_t IV1 = 32'hbb67ae85;
  localparam word_t IV2 = 32'h3c6ef372;
  localparam word_t IV3 = 32'ha54ff53a;
  localparam word_t IV4 = 32'h510e527f;
  localparam word_t IV5 = 32'h9b05688c;
  localparam word_t IV6 = 32'h1f83d9ab;
  localparam word_t IV7 = 32'h5be0cd19;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  // command from the byte sequencer to the compression engine
  typedef struct packed {
    logic start;
    logic final_blk;
  } cmp_cmd_t;

  // status back from the engine
  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    unique case (r)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/sha256_compress.sv
`timescale 1ns / 1ps
`include "sha256_stream_hash_core_assert.svh"
// one round per cycle; schedule window is a 16-word shift line loaded from the block
module sha256_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::cmp_cmd_t cmd,
  input  logic [511:0]         block,
  output sha256_pkg::cmp_sts_t sts,
  output logic [255:0]         hash
);
  import sha256_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_ADD  = 2'd2;

  logic [1:0] state;
  logic [5:0] round;
  logic       fin;
  word_t      hv [8];
  word_t      v  [8];
  word_t      w  [16];
  word_t      s0, s1, wnew, t1, t2, se, sa, ch, mj;

  always_comb begin
    s0   = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1   = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    se   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1   = v[7] + se + ch + round_k(round) + w[0];
    sa   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    mj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2   = sa + mj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      fin   <= 1'b0;
      hv[0] <= IV0; hv[1] <= IV1; hv[2] <= IV2; hv[3] <= IV3;
      hv[4] <= IV4; hv[5] <= IV5; hv[6] <= IV6; hv[7] <= IV7;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            state <= S_RUN;
            round <= '0;
            fin   <= cmd.final_blk;
            for (int i = 0; i < 8; i++) v[i] <= hv[i];
            for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
          end
        end
        S_RUN: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hv[i] <= hv[i] + v[i];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // after the digest is taken the chaining value restarts
      if (state == S_IDLE && fin && !cmd.start) begin
        fin   <= 1'b0;
        hv[0] <= IV0; hv[1] <= IV1; hv[2] <= IV2; hv[3] <= IV3;
        hv[4] <= IV4; hv[5] <= IV5; hv[6] <= IV6; hv[7] <= IV7;
      end
    end
  end

  assign sts.busy = (state != S_IDLE);
  assign sts.done = (state == S_ADD);
  for (genvar g = 0; g < 8; g++) begin : g_hash
    assign hash[255 - 32*g -: 32] = hv[g] + v[g];
  end

  `SHA_ASSERT_NEXT(a_add_after_last, state == S_RUN && round == 6'd63, state == S_ADD)
  `SHA_ASSERT_NEXT(a_idle_after_add, state == S_ADD, state == S_IDLE)
  `SHA_ASSERT_IMP(a_no_start_busy, state != S_IDLE, sts.busy)
endmodule

>>> hdl/sha256_stream_hash_core.sv
`timescale 1ns / 1ps
`include "sha256_stream_hash_core_assert.svh"
// channel | signals                                         | dir
// in      | in_valid in_ready in_byte byte_present end_of_message | in
// out     | out_valid out_ready digest_word word_index last_word  | out
// a plain byte request is taken while idle; the 64th byte of a block holds
// in_ready low through the start command, 64 rounds, one add and one release
// an end request pads (one or two blocks), then shows eight digest words,
// one per accepted output request
// rst is synchronous; clears counters, length and chaining value
// output stalls hold the word; no new input is taken until all eight leave
module sha256_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1; // waits for the engine after a full buffer or end request
  localparam logic [2:0] S_PADW = 3'd2; // first of two padding blocks running
  localparam logic [2:0] S_FINW = 3'd3; // final block running
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   state;
  logic [5:0]   byte_count;
  logic [63:0]  bit_length;
  logic [511:0] buffer;
  logic         want_end;
  logic [2:0]   oidx;
  logic [255:0] hash, dig;
  cmp_cmd_t     cmd;
  cmp_sts_t     sts;
  logic [511:0] pad_blk;
  logic [63:0]  total_len;
  logic         two_blk;
  logic         start_req;
  logic         final_req;

  sha256_compress u_cmp (
    .clk (clk), .rst (rst), .cmd (cmd), .block (buffer), .sts (sts), .hash (hash)
  );

  assign in_ready = (state == S_IDLE);
  assign total_len = bit_length + {55'd0, byte_count, 3'd0};
  assign two_blk = (byte_count >= LEN_POS);

  // padded buffer: bytes below the count kept, marker, zeros, optional length
  always_comb begin
    pad_blk = buffer;
    for (int i = 0; i < 64; i++) begin
      if (6'(i) == byte_count) pad_blk[511 - 8*i -: 8] = PAD_BYTE;
      else if (6'(i) > byte_count) pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    if (!two_blk) pad_blk[63:0] = total_len;
  end

  // engine start: a full buffer, or a padding block once the engine is free
  always_comb begin
    start_req = 1'b0;
    final_req = 1'b0;
    if (state == S_IDLE) begin
      start_req = in_valid && byte_present && (byte_count == 6'd63);
    end else if ((state == S_WAIT && want_end) || state == S_PADW) begin
      start_req = !cmd.start && !sts.busy;
      final_req = (state == S_PADW) || !two_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd <= '0;
    end else begin
      cmd <= '{start: start_req, final_blk: start_req && final_req};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      bit_length <= '0;
      want_end   <= 1'b0;
      oidx       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            want_end <= end_of_message;
            if (byte_present) begin
              buffer[511 - 8*byte_count -: 8] <= in_byte;
              if (byte_count == 6'd63) begin
                state      <= S_WAIT;
                bit_length <= bit_length + 64'd512;
              end else if (end_of_message) begin
                state <= S_WAIT;
              end
              byte_count <= byte_count + 6'd1;
            end else if (end_of_message) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          // after full block or end; engine free: pad if want_end, else idle
          if (!cmd.start && !sts.busy) begin
            if (!want_end) state <= S_IDLE;
            else begin
              buffer <= pad_blk;
              if (two_blk) state <= S_PADW;
              else state <= S_FINW;
            end
          end
        end
        S_PADW: begin
          if (!cmd.start && !sts.busy) begin
            buffer <= {448'd0, total_len};
            state  <= S_FINW;
          end
        end
        S_FINW: begin
          if (sts.done) begin
            dig   <= hash;
            oidx  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          byte_count <= '0;
          bit_length <= '0;
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid   = (state == S_OUT);
  assign digest_word = dig[255 - 32*oidx -: 32];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  `SHA_ASSERT_IMP(a_out_idle_exclusive, out_valid, !in_ready)
  `SHA_ASSERT_NEXT(a_words_advance, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)
  `SHA_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last_word, in_ready)
endmodule

>>> tb/sha256_stream_hash_core_test.sv
`timescale 1ns / 1ps
module sha256_stream_hash_core_test;

  // one expected digest word
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // running sha-256 of the byte stream plus the queue of digest words owed
  class digest_scoreboard;
    logic [31:0] hash_state[8];
    logic [7:0]  blk_bytes[64];
    int unsigned fill;
    logic [63:0] msg_bits;
    digest_word_t owed[$];
    int errors;

    localparam logic [31:0] RK[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] HV[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
      32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      foreach (hash_state[i]) hash_state[i] = HV[i];
      fill = 0;
      msg_bits = '0;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[16];
      logic [31:0] v[8];
      logic [31:0] wr, s0, s1, t1, t2;
      for (int r = 0; r < 16; r++)
        w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
      foreach (v[i]) v[i] = hash_state[i];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          s0 = rotr(w[(r+1)%16], 7) ^ rotr(w[(r+1)%16], 18) ^ (w[(r+1)%16] >> 3);
          s1 = rotr(w[(r+14)%16], 17) ^ rotr(w[(r+14)%16], 19) ^ (w[(r+14)%16] >> 10);
          wr = w[r%16] + s0 + w[(r+9)%16] + s1;
          w[r%16] = wr;
        end
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wr;
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      foreach (v[i]) hash_state[i] += v[i];
    endfunction

    // absorb an accepted request; an end request queues the eight digest words
    function void note_request(logic [7:0] data, logic has_byte, logic eom);
      int unsigned pos;
      digest_word_t dw;
      if (has_byte) begin
        blk_bytes[fill] = data;
        fill++;
        if (fill == 64) begin
          compress();
          msg_bits += 512;
          fill = 0;
        end
      end
      if (!eom) return;
      pos = fill;
      blk_bytes[pos++] = 8'h80;
      if (pos > 56) begin
        while (pos < 64) blk_bytes[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) blk_bytes[pos++] = 8'h00;
      msg_bits += 64'(fill) * 8;
      for (int n = 0; n < 8; n++) blk_bytes[56+n] = msg_bits[63-8*n -: 8];
      compress();
      for (int n = 0; n < 8; n++) begin
        dw.word = hash_state[n];
        dw.index = 3'(n);
        dw.last = (n == 7);
        owed.push_back(dw);
      end
      restart();
    endfunction

    function void report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_word_t dw;
      if (owed.size() == 0) begin
        report($sformatf("unexpected digest word %h", word));
        return;
      end
      dw = owed.pop_front();
      if (word !== dw.word) report($sformatf("digest_word %h, want %h", word, dw.word));
      if (index !== dw.index) report($sformatf("word_index %0d, want %0d", index, dw.index));
      if (last !== dw.last) report($sformatf("last_word %b, want %b", last, dw.last));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard sb = new();
  int idle_pct = 38;      // chance of a gap on either side, in percent
  bit hold_req = 1'b0;    // asks the receiver for one long hold-off
  int req_count = 0;      // requests carrying a byte or an end
  int msg_count = 0;
  int quiet_cycles = 0;

  sha256_stream_hash_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .byte_present(byte_present), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one request from a falling edge and return on the falling edge
  // after it is taken; valid stays up between back-to-back requests
  task automatic offer(input logic [7:0] data, input logic has_byte, input logic eom);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= data;
    byte_present <= has_byte;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(data, has_byte, eom);
    if (has_byte || eom) req_count++;
    @(negedge clk);
  endtask

  // one message of len bytes; the end either rides on the last byte or
  // comes as a request of its own, with an occasional empty request mixed in
  task automatic send_message(input int len, input bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) offer(8'($urandom), 1'b0, 1'b0);
      offer(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) offer(8'($urandom), 1'b0, 1'b1);
    msg_count++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_word(digest_word, word_index, last_word);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= 3000) begin
      $display("sha256_stream_hash_core test failed");
      $finish;
    end
  end

  initial begin
    int len;
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    byte_present = 1'b0;
    end_of_message = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, single bytes at the extremes with the end
    offer(8'h00, 1'b0, 1'b1);
    offer(8'h00, 1'b1, 1'b1);
    offer(8'hff, 1'b1, 1'b1);
    // an empty request does nothing
    offer(8'ha5, 1'b0, 1'b0);
    // "abc" with the end on the last byte, then a short one ended separately
    offer(8'h61, 1'b1, 1'b0);
    offer(8'h62, 1'b1, 1'b0);
    offer(8'h63, 1'b1, 1'b1);
    offer(8'h5a, 1'b1, 1'b0);
    offer(8'h80, 1'b1, 1'b0);
    offer(8'h7f, 1'b1, 1'b0);
    offer(8'h01, 1'b0, 1'b1);

    // random messages; lengths cluster near the padding boundaries
    // (55 fits one block, 56..63 need an extra pad block, 64 fills exactly)
    while (req_count < 280 || msg_count < 6) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 12);
      else if (pick < 8) len = 55 + $urandom_range(0, 10);
      else len = $urandom_range(13, 130);
      // a stretch with no gaps at all
      idle_pct = (msg_count == 1 || msg_count == 2) ? 0 : 38;
      // receiver holds off while requests keep coming, so the input stalls
      if (msg_count == 3) hold_req = 1'b1;
      // sender waits until every owed word has come out
      if (msg_count == 5) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
      send_message(len, $urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sha256_stream_hash_core test passed");
    end else begin
      $display("sha256_stream_hash_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sha256_pkg.sv
hdl/sha256_compress.sv
hdl/sha256_stream_hash_core.sv
tb/sha256_stream_hash_core_test.sv
